[src/local_peak_detector_top_assert.svh]
// Assertion macros for the local peak detector checker.
`ifndef LOCAL_PEAK_DETECTOR_TOP_ASSERT_SVH
`define LOCAL_PEAK_DETECTOR_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LPD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LPD_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/lpd_pkg.sv]
`default_nettype none

package lpd_pkg;

    // Default widths and register reset values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 16;
    localparam int COUNT_BITS      = 16;
    localparam int GAP_BITS        = 16;
    localparam int WIN_DEPTH       = 5;
    localparam int CENTER_POS      = 2;
    localparam logic [GAP_BITS-1:0] MIN_GAP_RESET = 16'd33;

    // Control shared by all window cells
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[src/lpd_cell.sv]
`default_nettype none

// One candidate slot of the window: takes its newer neighbor's entry on shift.
module lpd_cell #(
    parameter int SAMPLE_BITS = lpd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = lpd_pkg::INDEX_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire lpd_pkg::cell_ctrl_t     ctrl,
    input  wire                          in_valid,
    input  wire        [INDEX_BITS-1:0]  in_index,
    input  wire signed [SAMPLE_BITS-1:0] in_value,
    output logic                         valid,
    output logic       [INDEX_BITS-1:0]  index,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic                          valid_reg;
    logic       [INDEX_BITS-1:0]   index_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;

    // Valid bit: cleared at record end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= in_valid;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    assign valid = valid_reg;
    assign index = index_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

[src/lpd_skid.sv]
`default_nettype none

// Output register plus one skid slot, so an item is taken while a result waits.
module lpd_skid #(
    parameter int DATA_W = 8
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Buffer steering
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[src/local_peak_detector_top.sv]
// Local peak detector with a refractory gap.
// Input channel s_*: one signed sample per item, s_last_sample marks the
// final sample of a record. Result channel m_*: at most one item per input,
// carrying a confirmed peak (m_is_peak) and/or the record total
// (m_record_end with m_peak_count). cfg_*: writes min_gap, always ready;
// write only while the block is idle.
// Throughput: one sample per clock while s_ready is high. All detection
// work for an item is done in the cycle it is accepted; its result is
// registered (skid slot if m_* stalls). Candidates move along a chain of
// four window cells; the new candidate completes the five-entry window.
// Stall: an output register and one skid slot hold results; s_ready drops
// only while both are full: a result arrived while one stalled on m_ready.
// Reset (aresetn low, synchronous): window, counters and buffers clear,
// min_gap returns to 33. A record end clears the record state likewise
// but keeps min_gap.
`default_nettype none

module local_peak_detector_top #(
    parameter int SAMPLE_BITS = lpd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = lpd_pkg::INDEX_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire        [lpd_pkg::GAP_BITS-1:0]    cfg_data,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire signed [SAMPLE_BITS-1:0]          s_sample,
    input  wire                                   s_last_sample,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_is_peak,
    output logic       [INDEX_BITS-1:0]           m_peak_index,
    output logic signed [SAMPLE_BITS-1:0]         m_peak_value,
    output logic       [lpd_pkg::COUNT_BITS-1:0]  m_peak_count,
    output logic                                  m_record_end
);

    localparam int WIN    = lpd_pkg::WIN_DEPTH;
    localparam int CTR    = lpd_pkg::CENTER_POS;
    localparam int CB     = lpd_pkg::COUNT_BITS;
    localparam int GB     = lpd_pkg::GAP_BITS;
    localparam int D2_W   = SAMPLE_BITS + 2;
    localparam int DIFF_W = ((INDEX_BITS > GB) ? INDEX_BITS : GB) + 2;
    localparam int DATA_W = 1 + INDEX_BITS + SAMPLE_BITS + CB + 1;

    logic [GB-1:0]                min_gap_reg;
    logic signed [SAMPLE_BITS-1:0] prev0_reg, prev1_reg;
    logic [INDEX_BITS-1:0]        count_reg, count_next;
    logic [INDEX_BITS-1:0]        last_peak_reg, last_peak_next;
    logic [CB-1:0]                peaks_reg, peaks_next;

    logic                         accept, cand, full, bigger, gap_ok, peak, has_result;
    logic signed [D2_W-1:0]       d2;
    logic signed [DIFF_W-1:0]     gap_diff, gap_lim;
    logic [INDEX_BITS-1:0]        cand_index;
    logic [CB-1:0]                count_inc;
    lpd_pkg::cell_ctrl_t          ctrl;
    logic [DATA_W-1:0]            res_data, out_data;
    logic                         buf_ready;

    // Cells 1..WIN-1 hold the newest candidates; the oldest entry drops out on shift
    logic                          cell_valid [1:WIN-1];
    logic        [INDEX_BITS-1:0]  cell_index [1:WIN-1];
    logic signed [SAMPLE_BITS-1:0] cell_value [1:WIN-1];
    logic                          link_valid [1:WIN-1];
    logic        [INDEX_BITS-1:0]  link_index [1:WIN-1];
    logic signed [SAMPLE_BITS-1:0] link_value [1:WIN-1];

    assign cfg_ready = 1'b1;
    assign s_ready   = buf_ready;
    assign accept    = s_valid && buf_ready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg <= lpd_pkg::MIN_GAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            min_gap_reg <= cfg_data;
        end
    end

    // Second difference; sample j is a candidate once sample j+1 is here
    assign d2 = D2_W'(s_sample) - (D2_W'(prev0_reg) <<< 1) + D2_W'(prev1_reg);
    assign cand = (count_reg >= INDEX_BITS'(2)) && d2[D2_W-1];
    assign cand_index = count_reg - INDEX_BITS'(1);

    // Window cells: slot WIN-1 takes the new candidate, the rest take their neighbor
    assign ctrl = '{shift: accept && cand, clear: accept && s_last_sample};

    for (genvar k = 1; k < WIN; k++) begin : g_cell
        if (k == WIN - 1) begin : g_head
            assign link_valid[k] = 1'b1;
            assign link_index[k] = cand_index;
            assign link_value[k] = prev0_reg;
        end else begin : g_link
            assign link_valid[k] = cell_valid[k+1];
            assign link_index[k] = cell_index[k+1];
            assign link_value[k] = cell_value[k+1];
        end
        lpd_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .in_valid(link_valid[k]),
            .in_index(link_index[k]),
            .in_value(link_value[k]),
            .valid   (cell_valid[k]),
            .index   (cell_index[k]),
            .value   (cell_value[k])
        );
    end

    // Peak test on the stored cells plus the incoming candidate, before this shift
    assign full   = cell_valid[1] && cell_valid[2] && cell_valid[3] && cell_valid[4];
    assign bigger = (cell_value[CTR+1] > cell_value[1]) &&
                    (cell_value[CTR+1] > cell_value[2]) &&
                    (cell_value[CTR+1] > cell_value[4]) &&
                    (cell_value[CTR+1] > prev0_reg);
    assign gap_diff = $signed(DIFF_W'(cell_index[CTR+1])) - $signed(DIFF_W'(last_peak_reg));
    assign gap_lim  = $signed(DIFF_W'(min_gap_reg));
    assign gap_ok   = gap_diff > gap_lim;
    assign peak     = cand && full && bigger && gap_ok;

    assign count_inc  = (&peaks_reg) ? peaks_reg : CB'(peaks_reg + 1'b1);
    assign has_result = peak || s_last_sample;

    // Record state update
    always_comb begin
        count_next     = count_reg;
        last_peak_next = last_peak_reg;
        peaks_next     = peaks_reg;
        if (accept) begin
            if (s_last_sample) begin
                count_next     = '0;
                last_peak_next = '0;
                peaks_next     = '0;
            end else begin
                if (!(&count_reg)) begin
                    count_next = INDEX_BITS'(count_reg + 1'b1);
                end
                if (peak) begin
                    last_peak_next = cell_index[CTR+1];
                    peaks_next     = count_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            last_peak_reg <= '0;
            peaks_reg     <= '0;
        end else begin
            count_reg     <= count_next;
            last_peak_reg <= last_peak_next;
            peaks_reg     <= peaks_next;
        end
    end

    // Sample history; read only once two samples of the record are in
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev1_reg <= prev0_reg;
            prev0_reg <= s_sample;
        end
    end

    // Result item
    assign res_data = {peak,
                       peak ? cell_index[CTR+1] : {INDEX_BITS{1'b0}},
                       peak ? cell_value[CTR+1] : {SAMPLE_BITS{1'b0}},
                       peak ? count_inc : peaks_reg,
                       s_last_sample};

    lpd_skid #(
        .DATA_W(DATA_W)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid && has_result),
        .in_ready (buf_ready),
        .in_data  (res_data),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign {m_is_peak, m_peak_index, m_peak_value, m_peak_count, m_record_end} = out_data;

endmodule

`default_nettype wire

[src/lpd_checker.sv]
`default_nettype none

`include "local_peak_detector_top_assert.svh"

// Port-level checks of the peak detector
module lpd_checker #(
    parameter int SAMPLE_BITS = lpd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = lpd_pkg::INDEX_BITS_DEF
) (
    input wire                                   aclk,
    input wire                                   aresetn,
    input wire                                   s_ready,
    input wire                                   m_valid,
    input wire                                   m_ready,
    input wire                                   m_is_peak,
    input wire        [INDEX_BITS-1:0]           m_peak_index,
    input wire signed [SAMPLE_BITS-1:0]          m_peak_value,
    input wire        [lpd_pkg::COUNT_BITS-1:0]  m_peak_count,
    input wire                                   m_record_end
);

    // A stalled result holds
    `LPD_ASSERT_CLK(a_out_hold, (m_valid && !m_ready |=> m_valid && $stable(m_peak_index) && $stable(m_peak_value) && $stable(m_peak_count) && $stable(m_is_peak) && $stable(m_record_end)), "stalled result changed")

    // Nothing is offered right after reset
    `LPD_ASSERT_ALL(a_reset_empty, (!aresetn |=> !m_valid), "result valid after reset")

    // Every result carries a peak or a record end
    `LPD_ASSERT_CLK(a_has_cause, (m_valid |-> (m_is_peak || m_record_end)), "empty result item")

    // A record end without peak reports zero index and value
    `LPD_ASSERT_CLK(a_no_peak_zero, (m_valid && !m_is_peak |-> (m_peak_index == 0) && (m_peak_value == 0)), "stale peak fields")

    // Input back-pressure only while a result is waiting
    `LPD_ASSERT_CLK(a_ready_cause, (!s_ready |-> m_valid), "input stalled with empty output")

endmodule

bind local_peak_detector_top lpd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_lpd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_peak   (m_is_peak),
    .m_peak_index(m_peak_index),
    .m_peak_value(m_peak_value),
    .m_peak_count(m_peak_count),
    .m_record_end(m_record_end)
);

`default_nettype wire
